// ===== hw/rtl/rsr_pkg.sv =====
// ----------------------------------------------------------------------------
// rsr_pkg
// shared types and constants of the ratio scaler with remainder carry
// ----------------------------------------------------------------------------
package rsr_pkg;

  // event field widths
  localparam int unsigned TYPE_W  = 8;
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned VALUE_W = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned COUNT_W    = 3;

  // default number of code slots
  localparam int unsigned MAX_CODES_DEF = 4;

  // axis codes that carry a remainder
  localparam logic [CODE_W-1:0] CODE_WHEEL  = 16'h0008;
  localparam logic [CODE_W-1:0] CODE_HWHEEL = 16'h0006;

  // reset values of the configuration registers
  localparam logic [TYPE_W-1:0]     RST_MATCH_TYPE  = 8'd2;
  localparam logic [CFG_DATA_W-1:0] RST_MATCH_CODES = 64'h0000_0000_0006_0008;
  localparam logic [COUNT_W-1:0]    RST_CODE_COUNT  = 3'd2;
  localparam logic [VALUE_W-1:0]    RST_NUMERATOR   = 16'd1;
  localparam logic [VALUE_W-1:0]    RST_DENOMINATOR = 16'd1;

  // divider sizes: 32-bit dividend magnitude, one quotient bit a step
  localparam int unsigned DIVIDEND_W = 32;
  localparam int unsigned DIVISOR_W  = 16;
  localparam int unsigned DIV_STEPS  = DIVIDEND_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH_TYPE  = 3'd0,
    CFG_MATCH_CODES = 3'd1,
    CFG_CODE_COUNT  = 3'd2,
    CFG_NUMERATOR   = 3'd3,
    CFG_DENOMINATOR = 3'd4,
    CFG_INVERT      = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quot;
    logic [DIVISOR_W-1:0]  rem;
  } div_res_t;

endpackage

// ===== hw/rtl/ratio_scaler_with_remainder_top.sv =====
// ----------------------------------------------------------------------------
// ratio_scaler_with_remainder_top
// scales matched input events by numerator / denominator with remainder carry
// ----------------------------------------------------------------------------
// usage
//   input stream: one beat per event; tuser carries the event type, tdata the
//   event code and signed value. output stream: one beat per input beat;
//   tdata is the value, tuser the was-scaled flag.
//   an event whose type matches and whose code sits in one of the enabled
//   slots is multiplied by the numerator (negated when invert is set), gets
//   the wheel or hwheel remainder added for those two axes, and is divided
//   by the denominator with truncation toward zero; the leftover becomes
//   the axis's new remainder. other events pass with the value untouched.
// sequencing
//   one event at a time. a scaled event runs through the multiply state,
//   the divider load state, the shared restoring divider (one quotient bit
//   a step), the divider's done flag and the done state, which loads the
//   output register; a pass-through event goes from the multiply state to
//   the done state. tready is high only while the sequencer is idle.
// reset and stalls
//   reset loads the register defaults and clears both remainders. a finished
//   beat waits in the output register while the receiver stalls; the next
//   event is still accepted and runs up to its hand-off meanwhile.
// the user, not the block, ensures configuration is written only while idle
// ----------------------------------------------------------------------------
module ratio_scaler_with_remainder_top #(
  parameter int unsigned MaxCodes = rsr_pkg::MAX_CODES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input event stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [31:0]                      s_axis_tdata_i,  // event_code, event_value
  input  logic [rsr_pkg::TYPE_W-1:0]       s_axis_tuser_i,  // event_type
  // output event stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [rsr_pkg::VALUE_W-1:0]      m_axis_tdata_o,  // value_out
  output logic                             m_axis_tuser_o,  // was_scaled
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [rsr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rsr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import rsr_pkg::*;

  localparam int unsigned CodeBits = MaxCodes * CODE_W;
  localparam logic [CodeBits-1:0] CodesRst = CodeBits'(RST_MATCH_CODES);

  // configuration registers
  logic [TYPE_W-1:0]         match_type_q;
  logic [CodeBits-1:0]       match_codes_q;
  logic [COUNT_W-1:0]        code_count_q;
  logic signed [VALUE_W-1:0] numerator_q;
  logic signed [VALUE_W-1:0] denominator_q;
  logic                      invert_q;

  // axis remainders
  logic signed [VALUE_W-1:0] wheel_rem_q, wheel_rem_d;
  logic signed [VALUE_W-1:0] hwheel_rem_q, hwheel_rem_d;

  // sequencer
  state_e state_q, state_d;

  // captured event
  logic signed [VALUE_W-1:0] raw_q;
  logic                      matched_q;
  logic                      is_wheel_q;
  logic                      is_hwheel_q;

  // arithmetic
  logic signed [DIVIDEND_W-1:0] acc_q;
  logic signed [DIVIDEND_W-1:0] acc_d;
  logic signed [VALUE_W:0]      num_eff;
  logic signed [VALUE_W-1:0]    den_eff;
  logic signed [VALUE_W-1:0]    rem_sel;
  logic signed [DIVIDEND_W:0]   prod;
  logic [DIVIDEND_W-1:0]        acc_mag;
  logic [DIVISOR_W-1:0]         den_mag;
  logic [DIVIDEND_W-1:0]        quot_s;
  logic [DIVISOR_W-1:0]         rem_s;
  div_res_t                     div_res;

  // event match
  logic [CODE_W-1:0] in_code;
  logic              code_hit;

  // output register
  logic                      m_valid_q, m_valid_d;
  logic [VALUE_W-1:0]        m_value_q;
  logic                      m_scaled_q;

  // sequencer outputs
  logic in_ready;
  logic mul_en;
  logic div_start;
  logic out_load;
  logic out_free;

  assign in_code  = s_axis_tdata_i[CODE_W-1:0];
  assign out_free = !m_valid_q || m_axis_tready_i;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_type_q  <= RST_MATCH_TYPE;
      match_codes_q <= CodesRst;
      code_count_q  <= RST_CODE_COUNT;
      numerator_q   <= RST_NUMERATOR;
      denominator_q <= RST_DENOMINATOR;
      invert_q      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MATCH_TYPE:  match_type_q  <= cfg_wdata_i[TYPE_W-1:0];
        CFG_MATCH_CODES: match_codes_q <= cfg_wdata_i[CodeBits-1:0];
        CFG_CODE_COUNT:  code_count_q  <= cfg_wdata_i[COUNT_W-1:0];
        CFG_NUMERATOR:   numerator_q   <= cfg_wdata_i[VALUE_W-1:0];
        CFG_DENOMINATOR: denominator_q <= cfg_wdata_i[VALUE_W-1:0];
        CFG_INVERT:      invert_q      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- code match ----------------
  // only slots below code_count take part; the slot count also caps it
  always_comb begin
    code_hit = 1'b0;
    for (int i = 0; i < MaxCodes; i++) begin
      if ((i < int'(code_count_q)) && (match_codes_q[i*CODE_W +: CODE_W] == in_code)) begin
        code_hit = 1'b1;
      end
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_axis_tvalid_i) state_d = ST_MUL;
      ST_MUL:   state_d = matched_q ? ST_START : ST_DONE;
      ST_START: state_d = ST_WAIT;
      ST_WAIT:  if (div_res.done) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mul_en    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready  = 1'b1;
      ST_MUL:   mul_en    = 1'b1;
      ST_START: div_start = 1'b1;
      ST_WAIT:  ;
      ST_DONE:  out_load  = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // capture the event on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_q   <= 1'b0;
      is_wheel_q  <= 1'b0;
      is_hwheel_q <= 1'b0;
    end else if (in_ready && s_axis_tvalid_i) begin
      matched_q   <= (s_axis_tuser_i == match_type_q) && code_hit;
      is_wheel_q  <= in_code == CODE_WHEEL;
      is_hwheel_q <= in_code == CODE_HWHEEL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid_i) begin
      raw_q <= s_axis_tdata_i[CODE_W +: VALUE_W];
    end
  end

  // ---------------- multiply and remainder add ----------------
  always_comb begin
    num_eff = (numerator_q == '0) ? (VALUE_W+1)'(1) : (VALUE_W+1)'(numerator_q);
    if (invert_q) begin
      num_eff = -num_eff;
    end
    den_eff = (denominator_q == '0) ? VALUE_W'(1) : denominator_q;
    if (is_wheel_q) begin
      rem_sel = wheel_rem_q;
    end else if (is_hwheel_q) begin
      rem_sel = hwheel_rem_q;
    end else begin
      rem_sel = '0;
    end
    // |raw * num| stays at or below 2^30, so the sum fits 32 bits
    prod  = (DIVIDEND_W+1)'(raw_q) * (DIVIDEND_W+1)'(num_eff);
    acc_d = DIVIDEND_W'(prod + (DIVIDEND_W+1)'(rem_sel));
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      acc_q <= acc_d;
    end
  end

  // magnitudes into the divider; 0x8000 is the magnitude of the most negative den
  assign acc_mag = acc_q[DIVIDEND_W-1] ? DIVIDEND_W'(-acc_q) : DIVIDEND_W'(acc_q);
  assign den_mag = den_eff[VALUE_W-1] ? DIVISOR_W'(-den_eff) : DIVISOR_W'(den_eff);

  rsr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_mag),
    .divisor_i  (den_mag),
    .res_o      (div_res)
  );

  // truncating division: quotient sign from both operands, remainder from the dividend
  assign quot_s = (acc_q[DIVIDEND_W-1] ^ den_eff[VALUE_W-1]) ? -div_res.quot : div_res.quot;
  assign rem_s  = acc_q[DIVIDEND_W-1] ? -div_res.rem : div_res.rem;

  // ---------------- remainder update ----------------
  always_comb begin
    wheel_rem_d  = wheel_rem_q;
    hwheel_rem_d = hwheel_rem_q;
    if (out_load && matched_q) begin
      if (is_wheel_q) begin
        wheel_rem_d = rem_s;
      end else if (is_hwheel_q) begin
        hwheel_rem_d = rem_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_rem_q  <= '0;
      hwheel_rem_q <= '0;
    end else begin
      wheel_rem_q  <= wheel_rem_d;
      hwheel_rem_q <= hwheel_rem_d;
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_value_q  <= matched_q ? quot_s[VALUE_W-1:0] : raw_q;
      m_scaled_q <= matched_q;
    end
  end

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_value_q;
  assign m_axis_tuser_o  = m_scaled_q;

endmodule

// ===== hw/rtl/rsr_div.sv =====
// ----------------------------------------------------------------------------
// rsr_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rsr_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [rsr_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  logic [rsr_pkg::DIVISOR_W-1:0]    divisor_i,
  output rsr_pkg::div_res_t                res_o
);
  import rsr_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // partial remainder stays below the divisor, so it fits the low bits
      rem_d = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quo_q;
  assign res_o.rem  = rem_q;

endmodule

// ===== hw/rtl/rsr_checker.sv =====
// ----------------------------------------------------------------------------
// rsr_checker
// port-level checks of the ratio scaler, bound to the top level
// ----------------------------------------------------------------------------
module rsr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [rsr_pkg::VALUE_W-1:0]      m_axis_tdata_o,
  input logic                             m_axis_tuser_o
);
  import rsr_pkg::*;

  // no output beat while in reset
  a_no_out_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output beat shown during reset");

  // one event at a time: ready drops right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while an event is in flight");

  // a stalled output beat stays up
  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output beat dropped while stalled");

  // a stalled output beat keeps its value and flag
  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output payload changed while stalled");

endmodule

bind ratio_scaler_with_remainder_top rsr_checker u_rsr_checker (.*);
